FILE: hw/rtl/arx64_stream_cipher_xor_assert.svh
// Assertion macros shared by the cipher RTL.
`ifndef ARX64_STREAM_CIPHER_XOR_ASSERT_SVH
`define ARX64_STREAM_CIPHER_XOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ARX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ARX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/arx_pkg.sv
// Types, constants and helper functions of the 64-bit ARX stream cipher.
package arx_pkg;

    localparam int WORD_W     = 64;
    localparam int VB_W       = 4;
    localparam int TDATA_W    = 72;
    localparam int NUM_WORDS  = 16;
    localparam int LANES      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int DEFAULT_ROUND_COUNT = 20;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        step_t;

    localparam step_t LAST_STEP = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY0          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_COUNTER = 3'd6;

    localparam word_t SIGMA_HEAD [4] = '{
        64'h6170786593810fab, 64'h3320646ec7398aee,
        64'h79622d3217318274, 64'h6b206574babadada};
    localparam word_t SIGMA_MID [5] = '{
        64'h2ae36e593e46ad5f, 64'hb68f143029225fc9, 64'h8da1e08468303aa6,
        64'ha48a209acd50a4a7, 64'h7fdc12f23f90778c};

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FFWD,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic  ready;   // input side may take a beat
        logic  load;    // load working words from the input state
        logic  rnd_en;  // apply one quarter-round step on all four lanes
        logic  diag;    // diagonal round (else column round)
        step_t step;    // step within the quarter-round
        logic  ffwd;    // add input state, bump block counter
        logic  emit;    // write the output register
    } ctrl_t;

    // Fixed rotate right for each quarter-round step: 32, 24, 16, 63.
    function automatic word_t rotr_step(input word_t v, input step_t s);
        word_t r;
        case (s)
            2'd0:    r = {v[31:0], v[63:32]};
            2'd1:    r = {v[23:0], v[63:24]};
            2'd2:    r = {v[15:0], v[63:16]};
            default: r = {v[62:0], v[63]};
        endcase
        return r;
    endfunction

    // Low-byte mask for a valid byte count; counts above eight keep all bytes.
    function automatic word_t byte_mask(input logic [VB_W-1:0] vb);
        word_t m;
        for (int k = 0; k < WORD_W / 8; k++) begin
            m[8*k +: 8] = (vb > VB_W'(k)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/arx_qr_step.sv
// Shared quarter-round step unit: four lanes of add, xor and fixed rotate.
module arx_qr_step import arx_pkg::*; (
    input  word_t x_i  [LANES],
    input  word_t y_i  [LANES],
    input  word_t z_i  [LANES],
    input  step_t step_i,
    output word_t xn_o [LANES],
    output word_t zn_o [LANES]
);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            xn_o[i] = x_i[i] + y_i[i];
            zn_o[i] = rotr_step(z_i[i] ^ xn_o[i], step_i);
        end
    end

endmodule

FILE: hw/rtl/arx_seq.sv
// Sequencer: block load, round/step counting, feed-forward and output control.
`include "arx64_stream_cipher_xor_assert.svh"

module arx_seq import arx_pkg::*; #(
    parameter int ROUND_COUNT = DEFAULT_ROUND_COUNT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_accept,
    input  logic  need_block,
    input  logic  out_free,
    output ctrl_t ctrl
);

    // rounds go in column/diagonal pairs
    localparam int TOTAL_ROUNDS = 2 * ((ROUND_COUNT + 1) / 2);
    localparam int RND_W        = $clog2(TOTAL_ROUNDS);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(TOTAL_ROUNDS - 1);

    state_t           state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    step_t            step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rnd_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        step_next  = step_reg;
        ctrl       = '0;
        ctrl.diag  = rnd_reg[0];
        ctrl.step  = step_reg;
        case (state_reg)
            S_IDLE: begin
                ctrl.ready = 1'b1;
                if (in_accept) begin
                    state_next = need_block ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD: begin
                ctrl.load  = 1'b1;
                rnd_next   = '0;
                step_next  = '0;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                ctrl.rnd_en = 1'b1;
                step_next   = step_reg + 2'd1;
                if (step_reg == LAST_STEP) begin
                    if (rnd_reg == RND_LAST) begin
                        state_next = S_FFWD;
                    end else begin
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                end
            end
            S_FFWD: begin
                ctrl.ffwd  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ARX_ASSERT_NEXT(a_load_clears, aclk, aresetn, state_reg == S_LOAD,
        rnd_reg == '0 && step_reg == '0, "round counters not cleared on load")
    `ARX_ASSERT_NEXT(a_round_exit, aclk, aresetn,
        state_reg == S_ROUND && step_reg == LAST_STEP && rnd_reg == RND_LAST,
        state_reg == S_FFWD, "last round step did not go to feed-forward")
    `ARX_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn,
        state_reg == S_IDLE && in_accept,
        state_reg == S_LOAD || state_reg == S_EMIT, "accepted beat left no work")

endmodule

FILE: hw/rtl/arx64_stream_cipher_xor.sv
// Flow: an accepted beat within a block goes from S_IDLE straight to S_EMIT; a beat that
// opens a 128-byte block (first of a message or word index 0) first runs S_LOAD, R rounds
// in S_ROUND and S_FFWD, R = ROUND_COUNT rounded up to even, one quarter-round step of all
// four lanes per cycle. S_EMIT writes the output register and raises m_tvalid once the
// register is free; no new beat is taken until then. The single shared step unit sets the block time.
// Reset: synchronous, active-low aresetn clears control, key/nonce to 0, start counter to 1.
`include "arx64_stream_cipher_xor_assert.svh"

module arx64_stream_cipher_xor import arx_pkg::*; #(
    parameter int ROUND_COUNT = DEFAULT_ROUND_COUNT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [63:0] in_word, [67:64] valid_bytes, pad zero
    input  logic                 s_tlast,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [63:0] out_word, [67:64] out_valid_bytes, 0
    output logic                 m_tlast
);

    ctrl_t ctrl;

    // config registers
    word_t key_reg [4];
    word_t nonce_low_reg, nonce_high_reg, start_counter_reg;

    // block state
    word_t            work_reg [NUM_WORDS];   // round words, then keystream after feed-forward
    word_t            work_rnd [NUM_WORDS];
    word_t            init_w   [NUM_WORDS];
    word_t            block_counter_reg;
    logic [3:0]       word_index_reg;
    logic             message_start_reg;

    // held input beat
    word_t            word_hold_reg;
    logic [VB_W-1:0]  vb_hold_reg;
    logic             last_hold_reg;

    // output register
    logic             m_tvalid_reg;
    word_t            out_word_reg;
    logic [VB_W-1:0]  out_vb_reg;
    logic             out_last_reg;

    logic in_accept, cfg_accept, need_block, out_free;

    // step unit lanes
    word_t a_w [LANES], b_w [LANES], c_w [LANES], d_w [LANES];
    word_t x_w [LANES], y_w [LANES], z_w [LANES];
    word_t xn_w [LANES], zn_w [LANES];
    word_t na_w [LANES], nb_w [LANES], nc_w [LANES], nd_w [LANES];

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = ctrl.ready;
    assign in_accept  = s_tvalid && s_tready;
    // a new block is due at message start or when the block is used up
    assign need_block = message_start_reg || (word_index_reg == '0);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W - WORD_W - VB_W){1'b0}}, out_vb_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    arx_seq #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .need_block (need_block),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    // config writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                key_reg[k] <= '0;
            end
            nonce_low_reg     <= '0;
            nonce_high_reg    <= '0;
            start_counter_reg <= 64'd1;
        end else if (cfg_accept) begin
            case (cfg_index)
                REG_KEY0:          key_reg[0]        <= cfg_data;
                REG_KEY1:          key_reg[1]        <= cfg_data;
                REG_KEY2:          key_reg[2]        <= cfg_data;
                REG_KEY3:          key_reg[3]        <= cfg_data;
                REG_NONCE_LOW:     nonce_low_reg     <= cfg_data;
                REG_NONCE_HIGH:    nonce_high_reg    <= cfg_data;
                REG_START_COUNTER: start_counter_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input state of the block
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            init_w[k]     = SIGMA_HEAD[k];
            init_w[4 + k] = key_reg[k];
        end
        for (int k = 0; k < 5; k++) begin
            init_w[8 + k] = SIGMA_MID[k];
        end
        init_w[13] = block_counter_reg;
        init_w[14] = nonce_low_reg;
        init_w[15] = nonce_high_reg;
    end

    // gather lane operands; the diagonal round rotates rows 1..3 by 1..3 words
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            a_w[i] = work_reg[i];
            b_w[i] = ctrl.diag ? work_reg[4 + ((i + 1) & 3)]  : work_reg[4 + i];
            c_w[i] = ctrl.diag ? work_reg[8 + ((i + 2) & 3)]  : work_reg[8 + i];
            d_w[i] = ctrl.diag ? work_reg[12 + ((i + 3) & 3)] : work_reg[12 + i];
            // even steps: a += b, d ^= a; odd steps: c += d, b ^= c
            x_w[i] = ctrl.step[0] ? c_w[i] : a_w[i];
            y_w[i] = ctrl.step[0] ? d_w[i] : b_w[i];
            z_w[i] = ctrl.step[0] ? b_w[i] : d_w[i];
        end
    end

    arx_qr_step u_step (
        .x_i    (x_w),
        .y_i    (y_w),
        .z_i    (z_w),
        .step_i (ctrl.step),
        .xn_o   (xn_w),
        .zn_o   (zn_w)
    );

    // scatter results back to their words
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            na_w[i] = ctrl.step[0] ? a_w[i]  : xn_w[i];
            nb_w[i] = ctrl.step[0] ? zn_w[i] : b_w[i];
            nc_w[i] = ctrl.step[0] ? xn_w[i] : c_w[i];
            nd_w[i] = ctrl.step[0] ? d_w[i]  : zn_w[i];
        end
        for (int j = 0; j < LANES; j++) begin
            work_rnd[j]      = na_w[j];
            work_rnd[4 + j]  = ctrl.diag ? nb_w[(j + 3) & 3] : nb_w[j];
            work_rnd[8 + j]  = ctrl.diag ? nc_w[(j + 2) & 3] : nc_w[j];
            work_rnd[12 + j] = ctrl.diag ? nd_w[(j + 1) & 3] : nd_w[j];
        end
    end

    // working words: load, rounds, then feed-forward leaves the keystream in place
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            work_reg <= init_w;
        end else if (ctrl.rnd_en) begin
            work_reg <= work_rnd;
        end else if (ctrl.ffwd) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                work_reg[k] <= work_reg[k] + init_w[k];
            end
        end
    end

    // input hold
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            word_hold_reg <= s_tdata[WORD_W-1:0];
            vb_hold_reg   <= s_tdata[WORD_W +: VB_W];
            last_hold_reg <= s_tlast;
        end
    end

    // message position and block counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_counter_reg <= '0;
            word_index_reg    <= '0;
            message_start_reg <= 1'b1;
        end else begin
            if (in_accept && message_start_reg) begin
                block_counter_reg <= start_counter_reg;
                word_index_reg    <= '0;
                message_start_reg <= 1'b0;
            end
            if (ctrl.ffwd) begin
                block_counter_reg <= block_counter_reg + 64'd1;
            end
            if (ctrl.emit) begin
                word_index_reg <= word_index_reg + 4'd1;
                if (last_hold_reg) begin
                    message_start_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            out_word_reg <= (word_hold_reg ^ work_reg[word_index_reg]) & byte_mask(vb_hold_reg);
            out_vb_reg   <= vb_hold_reg;
            out_last_reg <= last_hold_reg;
        end
    end

    `ARX_ASSERT_NEXT(a_counter_step, aclk, aresetn, ctrl.ffwd,
        block_counter_reg == $past(block_counter_reg) + 64'd1, "block counter not bumped")
    `ARX_ASSERT_NEXT(a_emit_valid, aclk, aresetn, ctrl.emit,
        m_tvalid_reg, "emitted beat not presented")
    `ARX_ASSERT_NEXT(a_block_on_start, aclk, aresetn, in_accept && message_start_reg,
        ctrl.load, "message start did not generate a block")

endmodule
